@@ rtl/bcd_pkg.sv @@
// Shared types, widths and helper functions for the Bezier curve evaluator.
package bcd_pkg;

    localparam int COEFF_W  = 32;
    localparam int WORK_W   = 42;
    localparam int MB_W     = 25;
    localparam int ACC_W    = 68;
    localparam int OUT_W    = 48;
    localparam int Q_W      = 31;
    localparam int PHASE_W  = 17;
    localparam int RATE_W   = 24;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;

    localparam logic [PHASE_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_ROWS   = 1'b1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MAC_MUL,
        MAC_ADD,
        MAC_FOLD
    } mac_op_t;

    typedef struct packed {
        logic    en;
        mac_op_t op;
    } mac_ctrl_t;

    // True when the value does not fit the signed output width.
    function automatic logic out_of_range(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-OUT_W:0] top;
        top = v[ACC_W-1:OUT_W-1];
        return !((&top) || (~|top));
    endfunction

    // Clamp a wide signed value to the output range.
    function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [ACC_W-1:0] v);
        logic signed [OUT_W-1:0] res;
        if (out_of_range(v)) begin
            res = v[ACC_W-1] ? OUT_MIN : OUT_MAX;
        end
        else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/bcd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/bcd_mac.sv @@
// Shared signed multiply-accumulate unit with one accumulator register.
module bcd_mac (
    input  logic                                clk,
    input  bcd_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [bcd_pkg::WORK_W-1:0]   a,
    input  logic signed [bcd_pkg::MB_W-1:0]     b,
    output logic signed [bcd_pkg::ACC_W-1:0]    sum
);

    logic signed [bcd_pkg::ACC_W-1:0] sum_reg;
    logic signed [bcd_pkg::ACC_W-1:0] prod;

    assign prod = bcd_pkg::ACC_W'(a * b);
    assign sum  = sum_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            case (ctrl.op)
                bcd_pkg::MAC_MUL:  sum_reg <= prod;
                bcd_pkg::MAC_ADD:  sum_reg <= sum_reg + prod;
                bcd_pkg::MAC_FOLD: sum_reg <= (sum_reg >>> bcd_pkg::FRAC_W) + prod;
                default:           sum_reg <= sum_reg;
            endcase
        end
    end

endmodule

@@ rtl/bezier_curve_with_derivatives_core.sv @@
// Top level of the Bezier curve evaluator with velocity and acceleration outputs.
//
// The block stores signed Q16.16 control coefficients for up to MAX_ROWS rows and
// evaluates, for each row in use, the position, the velocity (derivative curve times
// the phase rate) and the acceleration (second difference curve times the rate
// squared) at phase s. A load transfer writes one coefficient into the coefficient
// RAM and produces no result; an evaluate transfer produces one result transfer per
// row, rows in ascending order, with last_row set on the final one. All arithmetic
// runs on one shared multiply-accumulate unit under a small sequencer, and the
// de Casteljau working set lives in a rotating register line of MAX_COEFFS entries,
// so each reduction level or difference pass takes MAX_COEFFS rotation steps.
// An evaluate first forms the rate square, then for each row fetches the coefficients
// for each pass, runs the difference passes and de Casteljau levels, and scales and
// emits the results. The input is not ready while an evaluate is in progress; the
// last result is held in an output register, so a new transfer can be accepted while
// it waits. The coefficient RAM is not cleared at reset and must be written before
// its entries are used.
module bezier_curve_with_derivatives_core #(
    parameter int MAX_COEFFS = 8,
    parameter int MAX_ROWS   = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  func,
    input  logic [2:0]                            row_index,
    input  logic [2:0]                            coeff_index,
    input  logic signed [31:0]                    coeff_value,
    input  logic [16:0]                           curve_param,
    input  logic signed [23:0]                    param_rate,
    // Output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [2:0]                            row_out,
    output logic signed [47:0]                    position,
    output logic signed [47:0]                    velocity,
    output logic signed [47:0]                    acceleration,
    output logic                                  saturated,
    output logic                                  last_row,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bcd_pkg::ADDR_W-1:0]            paddr,
    input  logic [bcd_pkg::DATA_W-1:0]            pwdata,
    output logic [bcd_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready
);

    localparam int DEPTH     = MAX_ROWS * MAX_COEFFS;
    localparam int AW        = $clog2(DEPTH);
    localparam int JW        = $clog2(MAX_COEFFS);
    localparam int CNT_W     = $clog2(MAX_COEFFS + 1);
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_LIMIT = (MAX_ROWS < 8) ? MAX_ROWS : 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QMUL,
        S_QSAVE,
        S_FETCH,
        S_STEP,
        S_FINAL,
        S_EMIT
    } state_t;

    state_t                                 state_reg;
    logic [ROW_W-1:0]                       row_reg;
    logic [1:0]                             pass_reg;
    logic [1:0]                             diffs_reg;
    logic                                   mode_diff_reg;
    logic [CNT_W-1:0]                       n_reg;
    logic [JW-1:0]                          j_reg;
    logic [1:0]                             sub_reg;
    logic [CNT_W-1:0]                       cnt_reg;
    logic [bcd_pkg::PHASE_W-1:0]            s_reg;
    logic signed [bcd_pkg::RATE_W-1:0]      sdot_reg;
    logic [bcd_pkg::Q_W-1:0]                q_reg;
    logic signed [bcd_pkg::OUT_W-1:0]       pos_reg;
    logic signed [bcd_pkg::OUT_W-1:0]       vel_reg;
    logic                                   sat_reg;
    logic [2:0]                             deg_reg;
    logic [3:0]                             rows_reg;
    logic                                   out_valid_reg;
    logic [2:0]                             row_out_reg;
    logic signed [bcd_pkg::OUT_W-1:0]       position_reg;
    logic signed [bcd_pkg::OUT_W-1:0]       velocity_reg;
    logic signed [bcd_pkg::OUT_W-1:0]       acceleration_reg;
    logic                                   saturated_reg;
    logic                                   last_row_reg;

    logic signed [bcd_pkg::WORK_W-1:0]      w_reg [MAX_COEFFS];

    logic [CNT_W-1:0]                       m_eff;
    logic [3:0]                             rows_eff;
    logic                                   is_last;
    logic                                   step_active;
    logic                                   write_now;
    logic                                   w_shift;
    logic signed [bcd_pkg::WORK_W-1:0]      w_new;
    logic [bcd_pkg::PHASE_W-1:0]            s_clamped;
    logic [bcd_pkg::PHASE_W-1:0]            one_minus_s;
    logic                                   cfg_write;
    logic [CNT_W-1:0]                       n_dec;

    bcd_pkg::mac_ctrl_t                     mac_ctrl;
    logic signed [bcd_pkg::WORK_W-1:0]      mac_a;
    logic signed [bcd_pkg::MB_W-1:0]        mac_b;
    logic signed [bcd_pkg::ACC_W-1:0]       mac_sum;
    logic signed [bcd_pkg::ACC_W-1:0]       sum_shr;

    logic                                   ram_we;
    logic [AW-1:0]                          ram_waddr;
    logic                                   ram_re;
    logic [AW-1:0]                          ram_raddr;
    logic [bcd_pkg::COEFF_W-1:0]            ram_rdata;

    // Configuration registers: degree and row count; their effective values are clamped to the supported range.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            bcd_pkg::REG_DEGREE: prdata = {{(bcd_pkg::DATA_W-3){1'b0}}, deg_reg};
            bcd_pkg::REG_ROWS:   prdata = {{(bcd_pkg::DATA_W-4){1'b0}}, rows_reg};
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        if (deg_reg == 3'd0)
        begin
            m_eff = CNT_W'(1);
        end
        else if (int'(deg_reg) > MAX_COEFFS - 1)
        begin
            m_eff = CNT_W'(MAX_COEFFS - 1);
        end
        else
        begin
            m_eff = CNT_W'(deg_reg);
        end

        if (rows_reg == 4'd0)
        begin
            rows_eff = 4'd1;
        end
        else if (int'(rows_reg) > ROW_LIMIT)
        begin
            rows_eff = 4'(ROW_LIMIT);
        end
        else
        begin
            rows_eff = rows_reg;
        end
    end

    assign is_last     = (int'(row_reg) == int'(rows_eff) - 1);
    assign s_clamped   = (curve_param > bcd_pkg::ONE_Q16) ? bcd_pkg::ONE_Q16 : curve_param;
    assign one_minus_s = bcd_pkg::ONE_Q16 - s_reg;
    assign sum_shr     = mac_sum >>> bcd_pkg::FRAC_W;
    assign n_dec       = n_reg - CNT_W'(1);

    // A rotation step does arithmetic only while the step index is below the level
    // size; the remaining steps just rotate the line back into order.
    assign step_active = (CNT_W'(j_reg) < n_reg);
    assign write_now   = (state_reg == S_STEP) &&
                         (!step_active || (mode_diff_reg && sub_reg == 2'd1) ||
                          (!mode_diff_reg && sub_reg == 2'd2));

    // Coefficient RAM: loads write it while idle, evaluation fetches one row at a time.
    assign ram_we    = (state_reg == S_IDLE) && in_valid && (func == bcd_pkg::FUNC_LOAD) &&
                       (int'(row_index) < MAX_ROWS) && (int'(coeff_index) < MAX_COEFFS);
    assign ram_waddr = AW'(int'(row_index) * MAX_COEFFS + int'(coeff_index));
    assign ram_re    = (state_reg == S_FETCH) && (int'(cnt_reg) < MAX_COEFFS);
    assign ram_raddr = AW'(int'(row_reg) * MAX_COEFFS + int'(cnt_reg));

    bcd_ram #(
        .WIDTH (bcd_pkg::COEFF_W),
        .DEPTH (DEPTH)
    ) u_coeff_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (coeff_value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Operand selection for the shared multiply-accumulate unit.
    always_comb
    begin
        mac_ctrl.en = 1'b0;
        mac_ctrl.op = bcd_pkg::MAC_MUL;
        mac_a       = w_reg[0];
        mac_b       = '0;
        case (state_reg)
            S_QMUL:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = bcd_pkg::WORK_W'(sdot_reg);
                mac_b       = bcd_pkg::MB_W'(sdot_reg);
            end
            S_STEP:
            begin
                if (step_active)
                begin
                    if (mode_diff_reg)
                    begin
                        // Difference pass: factor times the forward difference.
                        mac_ctrl.en = (sub_reg == 2'd0);
                        mac_a       = w_reg[1] - w_reg[0];
                        mac_b       = $signed({{(bcd_pkg::MB_W-CNT_W){1'b0}}, n_reg});
                    end
                    else if (sub_reg == 2'd0)
                    begin
                        mac_ctrl.en = 1'b1;
                        mac_a       = w_reg[0];
                        mac_b       = $signed({{(bcd_pkg::MB_W-bcd_pkg::PHASE_W){1'b0}},
                                               one_minus_s});
                    end
                    else if (sub_reg == 2'd1)
                    begin
                        mac_ctrl.en = 1'b1;
                        mac_ctrl.op = bcd_pkg::MAC_ADD;
                        mac_a       = w_reg[1];
                        mac_b       = $signed({{(bcd_pkg::MB_W-bcd_pkg::PHASE_W){1'b0}},
                                               s_reg});
                    end
                end
            end
            S_FINAL:
            begin
                if (pass_reg == 2'd1 && sub_reg == 2'd0)
                begin
                    mac_ctrl.en = 1'b1;
                    mac_b       = bcd_pkg::MB_W'(sdot_reg);
                end
                else if (pass_reg == 2'd2 && sub_reg == 2'd0)
                begin
                    mac_ctrl.en = 1'b1;
                    mac_b       = $signed({{(bcd_pkg::MB_W-16){1'b0}}, q_reg[15:0]});
                end
                else if (pass_reg == 2'd2 && sub_reg == 2'd1)
                begin
                    // Adds the product with the high part of the rate square to the floored low part.
                    mac_ctrl.en = 1'b1;
                    mac_ctrl.op = bcd_pkg::MAC_FOLD;
                    mac_b       = $signed({{(bcd_pkg::MB_W-(bcd_pkg::Q_W-16)){1'b0}},
                                           q_reg[bcd_pkg::Q_W-1:16]});
                end
            end
            default:
            begin
                mac_ctrl.en = 1'b0;
            end
        endcase
    end

    bcd_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .sum  (mac_sum)
    );

    // Working line: shifts toward index zero, new value enters at the top.
    always_comb
    begin
        w_shift = 1'b0;
        w_new   = w_reg[0];
        if (state_reg == S_FETCH && cnt_reg != '0)
        begin
            w_shift = 1'b1;
            w_new   = bcd_pkg::WORK_W'($signed(ram_rdata));
        end
        else if (write_now)
        begin
            w_shift = 1'b1;
            if (!step_active)
            begin
                w_new = w_reg[0];
            end
            else if (mode_diff_reg)
            begin
                w_new = mac_sum[bcd_pkg::WORK_W-1:0];
            end
            else
            begin
                w_new = sum_shr[bcd_pkg::WORK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_shift)
        begin
            for (int k = 0; k < MAX_COEFFS - 1; k++)
            begin
                w_reg[k] <= w_reg[k+1];
            end
            w_reg[MAX_COEFFS-1] <= w_new;
        end
    end

    // Sequencer: per row, up to three passes (position, velocity, acceleration), each a
    // fetch, optional difference passes and de Casteljau levels; the last two are scaled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            row_reg          <= '0;
            pass_reg         <= '0;
            diffs_reg        <= '0;
            mode_diff_reg    <= 1'b0;
            n_reg            <= '0;
            j_reg            <= '0;
            sub_reg          <= '0;
            cnt_reg          <= '0;
            deg_reg          <= 3'd5;
            rows_reg         <= 4'd1;
            out_valid_reg    <= 1'b0;
            s_reg            <= '0;
            sdot_reg         <= '0;
            q_reg            <= '0;
            pos_reg          <= '0;
            vel_reg          <= '0;
            sat_reg          <= 1'b0;
            row_out_reg      <= '0;
            position_reg     <= '0;
            velocity_reg     <= '0;
            acceleration_reg <= '0;
            saturated_reg    <= 1'b0;
            last_row_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[2])
                    bcd_pkg::REG_DEGREE: deg_reg  <= pwdata[2:0];
                    bcd_pkg::REG_ROWS:   rows_reg <= pwdata[3:0];
                    default:             deg_reg  <= deg_reg;
                endcase
            end

            // The emit state refills the output register itself when it is taken.
            if (out_valid_reg && out_ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && func == bcd_pkg::FUNC_EVAL)
                    begin
                        s_reg     <= s_clamped;
                        sdot_reg  <= param_rate;
                        row_reg   <= '0;
                        state_reg <= S_QMUL;
                    end
                end
                S_QMUL:
                begin
                    state_reg <= S_QSAVE;
                end
                S_QSAVE:
                begin
                    q_reg     <= mac_sum[bcd_pkg::Q_W+15:16];
                    pass_reg  <= 2'd0;
                    cnt_reg   <= '0;
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (int'(cnt_reg) == MAX_COEFFS)
                    begin
                        j_reg         <= '0;
                        sub_reg       <= '0;
                        n_reg         <= m_eff;
                        diffs_reg     <= pass_reg;
                        mode_diff_reg <= (pass_reg != 2'd0);
                        state_reg     <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (!write_now)
                    begin
                        sub_reg <= sub_reg + 2'd1;
                    end
                    else
                    begin
                        sub_reg <= '0;
                        if (j_reg == JW'(MAX_COEFFS - 1))
                        begin
                            j_reg <= '0;
                            n_reg <= n_dec;
                            if (mode_diff_reg)
                            begin
                                diffs_reg <= diffs_reg - 2'd1;
                                if (diffs_reg == 2'd1)
                                begin
                                    mode_diff_reg <= 1'b0;
                                end
                            end
                            if (n_dec == '0)
                            begin
                                state_reg <= S_FINAL;
                            end
                        end
                        else
                        begin
                            j_reg <= j_reg + JW'(1);
                        end
                    end
                end
                S_FINAL:
                begin
                    case (pass_reg)
                        2'd0:
                        begin
                            pos_reg   <= bcd_pkg::OUT_W'(w_reg[0]);
                            pass_reg  <= 2'd1;
                            cnt_reg   <= '0;
                            state_reg <= S_FETCH;
                        end
                        2'd1:
                        begin
                            if (sub_reg == 2'd0)
                            begin
                                sub_reg <= 2'd1;
                            end
                            else
                            begin
                                sub_reg <= '0;
                                vel_reg <= bcd_pkg::clamp_out(sum_shr);
                                sat_reg <= bcd_pkg::out_of_range(sum_shr);
                                if (int'(m_eff) >= 2)
                                begin
                                    pass_reg  <= 2'd2;
                                    cnt_reg   <= '0;
                                    state_reg <= S_FETCH;
                                end
                                else
                                begin
                                    pass_reg  <= 2'd3;
                                    state_reg <= S_EMIT;
                                end
                            end
                        end
                        default:
                        begin
                            if (sub_reg != 2'd2)
                            begin
                                sub_reg <= sub_reg + 2'd1;
                            end
                            else
                            begin
                                sub_reg   <= '0;
                                state_reg <= S_EMIT;
                            end
                        end
                    endcase
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        row_out_reg   <= 3'(row_reg);
                        position_reg  <= pos_reg;
                        velocity_reg  <= vel_reg;
                        last_row_reg  <= is_last;
                        // The acceleration pass leaves its product in the accumulator;
                        // a degree-one curve has no acceleration.
                        if (pass_reg == 2'd2)
                        begin
                            acceleration_reg <= bcd_pkg::clamp_out(mac_sum);
                            saturated_reg    <= sat_reg || bcd_pkg::out_of_range(mac_sum);
                        end
                        else
                        begin
                            acceleration_reg <= '0;
                            saturated_reg    <= sat_reg;
                        end
                        pass_reg <= 2'd0;
                        cnt_reg  <= '0;
                        if (is_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            row_reg   <= row_reg + ROW_W'(1);
                            state_reg <= S_FETCH;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign row_out      = row_out_reg;
    assign position     = position_reg;
    assign velocity     = velocity_reg;
    assign acceleration = acceleration_reg;
    assign saturated    = saturated_reg;
    assign last_row     = last_row_reg;

    // An accepted evaluate transfer always occupies the sequencer.
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == bcd_pkg::FUNC_EVAL |=> !in_ready)
        else $error("evaluate transfer did not start the sequencer");

    // A saturated result has at least one output on a rail.
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (velocity == bcd_pkg::OUT_MAX || velocity == bcd_pkg::OUT_MIN ||
             acceleration == bcd_pkg::OUT_MAX || acceleration == bcd_pkg::OUT_MIN))
        else $error("saturation flag set with no clamped output");

    // The level size stays within the working line while levels run.
    a_level_size: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> (n_reg != '0) && (int'(n_reg) <= MAX_COEFFS - 1))
        else $error("de Casteljau level size out of range");

endmodule
